// ===== rtl/cordic_cartesian_to_polar_defines.svh =====
// assertion macros shared by the cartesian to polar converter
`ifndef CORDIC_CARTESIAN_TO_POLAR_DEFINES_SVH
`define CORDIC_CARTESIAN_TO_POLAR_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define CC2P_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define CC2P_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cc2p_pkg.sv =====
// shared constants, types and tables of the cartesian to polar converter
package cc2p_pkg;

   localparam int ITERATIONS = 16;
   localparam int DATA_WIDTH = 16;
   localparam int TABLE_LEN  = 24;
   localparam int NUM_CELLS  = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
   localparam int IDX_W      = $clog2(NUM_CELLS);

   localparam int COORD_W  = 15;
   localparam int RADIUS_W = 15;
   localparam int ANGLE_W  = 16;

   // x/y datapath: q.14 with room for the cordic gain on a sqrt(2) vector
   localparam int XY_W  = COORD_W + 3;
   // angle accumulator: DATA_WIDTH fraction bits, range beyond pi plus the table sum
   localparam int ACC_W = DATA_WIDTH + 4;

   localparam longint PI_Q32   = 64'sd13493037704;
   localparam longint GAIN_Q32 = 64'sd2608131496;

   localparam longint ATAN_Q32 [TABLE_LEN] = '{
      64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
      64'sd268086748,  64'sd134174063,  64'sd67103403,   64'sd33553749,
      64'sd16777131,   64'sd8388597,    64'sd4194303,    64'sd2097152,
      64'sd1048576,    64'sd524288,     64'sd262144,     64'sd131072,
      64'sd65536,      64'sd32768,      64'sd16384,      64'sd8192,
      64'sd4096,       64'sd2048,       64'sd1024,       64'sd512
   };

   // angle output scaling: q.DATA_WIDTH to q3.13
   localparam int ANGLE_RSHIFT = (DATA_WIDTH >= 13) ? (DATA_WIDTH - 13) : 0;
   localparam int ANGLE_LSHIFT = (DATA_WIDTH < 13) ? (13 - DATA_WIDTH) : 0;
   localparam longint ANGLE_RND =
      (ANGLE_RSHIFT == 0) ? 64'sd0 : (64'sd1 <<< (ANGLE_RSHIFT - 1));

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ACC_W-1:0] acc;
   } vec_type;

   // q.32 constant to accumulator format, round half up
   function automatic logic signed [ACC_W-1:0] to_acc(input longint q32);
      longint shift;
      longint rounded;
      shift = 64'sd32 - DATA_WIDTH;
      if (shift == 0) begin
         rounded = q32;
      end else begin
         rounded = (q32 + (64'sd1 <<< (shift - 1))) >>> shift;
      end
      return ACC_W'(rounded);
   endfunction

   function automatic logic signed [ACC_W-1:0] atan_acc(input logic [IDX_W-1:0] idx);
      return to_acc(ATAN_Q32[idx]);
   endfunction

   localparam logic signed [ACC_W-1:0] PI_ACC = to_acc(PI_Q32);

endpackage

// ===== rtl/cordic_cartesian_to_polar.sv =====
// top level of the pipelined cordic cartesian to polar converter
// usage:
//   request channel req_*: one point (x, y) in signed q1.14 per request
//   response channel rsp_*: radius in unsigned q1.14 and angle in q3.13 radians
//   every request gives exactly one response, in order
// path: a request passes through one mirror stage, one cell per cordic iteration,
//   then the multiply and output stages before its response
// throughput: one request per cycle while the response side accepts; each stage is
//   its own register and the iteration count sets the depth, not the rate
// stall: each stage holds its point while the next stage is full, so bubbles
//   close up and requests keep entering until every stage is occupied
// reset: synchronous, clears all stage valid flags; the pipe is empty after it
`include "cordic_cartesian_to_polar_defines.svh"

module cordic_cartesian_to_polar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [14:0] x_coord, [29:15] y_coord, [31:30] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [14:0] radius, [30:15] angle, [31] zero
);

   localparam int N = cc2p_pkg::NUM_CELLS;

   // unpacked request fields
   logic signed [cc2p_pkg::COORD_W-1:0] x_coord, y_coord;
   logic signed [cc2p_pkg::XY_W-1:0]    x_ext, y_ext;

   // mirror stage: points with negative x are turned through pi
   logic              prep_valid_ff, prep_valid_in;
   cc2p_pkg::vec_type prep_vec_ff, prep_vec_in;

   // chain links between stages, link 0 is the mirror stage output
   logic              link_valid [N+1];
   logic              link_ready [N+1];
   cc2p_pkg::vec_type link_vec   [N+1];

   logic [cc2p_pkg::RADIUS_W-1:0]       radius;
   logic signed [cc2p_pkg::ANGLE_W-1:0] angle;

   assign x_coord = req_tdata[cc2p_pkg::COORD_W-1:0];
   assign y_coord = req_tdata[2*cc2p_pkg::COORD_W-1:cc2p_pkg::COORD_W];
   assign x_ext   = cc2p_pkg::XY_W'(x_coord);
   assign y_ext   = cc2p_pkg::XY_W'(y_coord);

   assign req_tready = !prep_valid_ff || link_ready[0];

   always_comb begin
      if (x_ext < 0) begin
         // mirror through the origin, start from +pi or -pi by sign of y
         prep_vec_in.x   = -x_ext;
         prep_vec_in.y   = -y_ext;
         prep_vec_in.acc = (y_ext < 0) ? -cc2p_pkg::PI_ACC : cc2p_pkg::PI_ACC;
      end else begin
         prep_vec_in.x   = x_ext;
         prep_vec_in.y   = y_ext;
         prep_vec_in.acc = '0;
      end
      prep_valid_in = req_tready ? req_tvalid : prep_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= prep_valid_in;
      end
      if (req_tready && req_tvalid) begin
         prep_vec_ff <= prep_vec_in;
      end
   end

   assign link_valid[0] = prep_valid_ff;
   assign link_vec[0]   = prep_vec_ff;

   // one cell per iteration, cell k shifts by k and uses atan(2^-k)
   for (genvar k = 0; k < N; k++) begin : g_cell
      cc2p_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .iter_idx  (cc2p_pkg::IDX_W'(k)),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_vec    (link_vec[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_vec   (link_vec[k+1])
      );
   end

   // gain correction and output formatting, ends in the response register
   cc2p_post u_post (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (link_valid[N]),
      .in_ready   (link_ready[N]),
      .in_vec     (link_vec[N]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_radius (radius),
      .out_angle  (angle)
   );

   assign rsp_tdata = {1'b0, angle, radius};

   // requests are only held off when the whole pipe is backed up from the output
   `CC2P_ASSERT_IMPLIES(a_stall_from_output, !req_tready, rsp_tvalid && !rsp_tready,
      "request stalled while the response side is free")
   // an accepted request always lands in the mirror stage
   `CC2P_ASSERT_NEXT(a_request_enters, req_tvalid && req_tready, prep_valid_ff,
      "accepted request not held in the mirror stage")
   // the pipe comes out of reset empty
   `CC2P_ASSERT_IMPLIES(a_empty_after_reset, $past(reset), !rsp_tvalid && !prep_valid_ff,
      "pipeline not empty after reset")

endmodule

// ===== rtl/cc2p_cell.sv =====
// one cordic vectoring iteration with its own pipeline register
module cc2p_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [cc2p_pkg::IDX_W-1:0]    iter_idx,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  cc2p_pkg::vec_type             in_vec,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cc2p_pkg::vec_type             out_vec
);

   logic              valid_ff, valid_in;
   cc2p_pkg::vec_type vec_ff, vec_in;
   logic signed [cc2p_pkg::XY_W-1:0]  x_shr, y_shr;
   logic signed [cc2p_pkg::ACC_W-1:0] atan_val;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

   always_comb begin
      x_shr    = in_vec.x >>> iter_idx;
      y_shr    = in_vec.y >>> iter_idx;
      atan_val = cc2p_pkg::atan_acc(iter_idx);
      // rotate toward y = 0, sign of y picks the direction
      if (in_vec.y < 0) begin
         vec_in.x   = in_vec.x - y_shr;
         vec_in.y   = in_vec.y + x_shr;
         vec_in.acc = in_vec.acc - atan_val;
      end else begin
         vec_in.x   = in_vec.x + y_shr;
         vec_in.y   = in_vec.y - x_shr;
         vec_in.acc = in_vec.acc + atan_val;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

endmodule

// ===== rtl/cc2p_post.sv =====
// gain multiply, rounding and saturation of radius and angle, output register
module cc2p_post (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  cc2p_pkg::vec_type                    in_vec,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [cc2p_pkg::RADIUS_W-1:0]        out_radius,
   output logic signed [cc2p_pkg::ANGLE_W-1:0]  out_angle
);

   localparam int PROD_W = cc2p_pkg::XY_W + 33;
   localparam int RAD_W  = PROD_W - 32;
   localparam int ANG_W  = cc2p_pkg::ACC_W + cc2p_pkg::ANGLE_LSHIFT + 1;

   localparam logic signed [32:0] GAIN_S = 33'(cc2p_pkg::GAIN_Q32);
   localparam logic signed [PROD_W-1:0] RAD_RND =
      {{(PROD_W-32){1'b0}}, 1'b1, 31'b0};
   localparam logic signed [RAD_W-1:0] RAD_MAX =
      {{(RAD_W-cc2p_pkg::RADIUS_W){1'b0}}, {cc2p_pkg::RADIUS_W{1'b1}}};
   localparam logic signed [ANG_W-1:0] ANG_RND = ANG_W'(cc2p_pkg::ANGLE_RND);
   localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(32767);
   localparam logic signed [ANG_W-1:0] ANG_MIN = ANG_W'(-32768);

   // multiply stage
   logic                                 mul_valid_ff, mul_valid_in;
   logic signed [PROD_W-1:0]             prod_ff, prod_in;
   logic signed [cc2p_pkg::ANGLE_W-1:0]  angle_ff, angle_in;
   logic signed [ANG_W-1:0]              ang_wide;
   logic                                 mul_ready;

   // output stage
   logic                                 out_valid_ff, out_valid_in;
   logic [cc2p_pkg::RADIUS_W-1:0]        radius_ff, radius_in;
   logic signed [cc2p_pkg::ANGLE_W-1:0]  angle_out_ff;
   logic signed [PROD_W-1:0]             rnd_sum;
   logic signed [RAD_W-1:0]              rad_wide;

   assign in_ready   = !mul_valid_ff || mul_ready;
   assign mul_ready  = !out_valid_ff || out_ready;
   assign out_valid  = out_valid_ff;
   assign out_radius = radius_ff;
   assign out_angle  = angle_out_ff;

   always_comb begin
      prod_in  = in_vec.x * GAIN_S;
      ang_wide = ((ANG_W'(in_vec.acc) + ANG_RND) >>> cc2p_pkg::ANGLE_RSHIFT)
                 <<< cc2p_pkg::ANGLE_LSHIFT;
      if (ang_wide > ANG_MAX) begin
         angle_in = cc2p_pkg::ANGLE_W'(ANG_MAX);
      end else if (ang_wide < ANG_MIN) begin
         angle_in = cc2p_pkg::ANGLE_W'(ANG_MIN);
      end else begin
         angle_in = cc2p_pkg::ANGLE_W'(ang_wide);
      end
      mul_valid_in = in_ready ? in_valid : mul_valid_ff;
   end

   always_comb begin
      rnd_sum  = prod_ff + RAD_RND;
      rad_wide = RAD_W'(rnd_sum >>> 32);
      if (rad_wide < 0) begin
         radius_in = '0;
      end else if (rad_wide > RAD_MAX) begin
         radius_in = cc2p_pkg::RADIUS_W'(RAD_MAX);
      end else begin
         radius_in = cc2p_pkg::RADIUS_W'(rad_wide);
      end
      out_valid_in = mul_ready ? mul_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (in_ready && in_valid) begin
         prod_ff  <= prod_in;
         angle_ff <= angle_in;
      end
      if (mul_ready && mul_valid_ff) begin
         radius_ff    <= radius_in;
         angle_out_ff <= angle_ff;
      end
   end

endmodule
